/* hw/rtl/bcme_pkg.sv */
`default_nettype none

package bcme_pkg;

	// Block size in bytes
	localparam int BLOCK_BYTES = 4;

	// Fixed field widths
	localparam int KEY_W      = 8;
	localparam int IV_W       = 32;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Op queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_CFB = 2'd2,
		MODE_OFB = 2'd3
	} mode_t;

	localparam logic DIR_ENC = 1'b0;
	localparam logic DIR_DEC = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY  = 2'd0,
		REG_MODE = 2'd1,
		REG_DIR  = 2'd2,
		REG_IV   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		mode_t            mode;
		logic             dir;
		logic [IV_W-1:0]  iv;
	} cfg_t;

	// Per-op control carried through the queue
	typedef struct packed {
		logic first;   // reload chain from IV
		logic last;    // tag result as final
		logic strip;   // report byte count after zero strip
	} op_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/bcme_if.sv */
`default_nettype none

interface bcme_in_if #(parameter int DATA_W = 32) ();
	import bcme_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] in_block;
	logic              first_block;
	logic              last_block;
	logic [CNT_W-1:0]  valid_bytes;

	modport source (output valid, in_block, first_block, last_block, valid_bytes,
		input ready);
	modport sink (input valid, in_block, first_block, last_block, valid_bytes,
		output ready);
endinterface

interface bcme_out_if #(parameter int DATA_W = 32) ();
	import bcme_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_block;
	logic              out_last;
	logic [CNT_W-1:0]  out_bytes;

	modport source (output valid, out_block, out_last, out_bytes, input ready);
	modport sink (input valid, out_block, out_last, out_bytes, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bcme_fifo.sv */
`default_nettype none

module bcme_fifo #(
	parameter int DATA_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire bcme_pkg::op_ctrl_t push_ctrl,
	input  wire logic             pop,
	output logic [DATA_W-1:0]     head_data,
	output bcme_pkg::op_ctrl_t    head_ctrl,
	output logic                  empty,
	output logic                  full
);
	import bcme_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] data_q [QUEUE_DEPTH];
	op_ctrl_t          ctrl_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty     = (fill_q == '0);
	assign full      = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign head_data = data_q[rd_ptr_q];
	assign head_ctrl = ctrl_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
			ctrl_q[wr_ptr_q] <= push_ctrl;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("op queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("op queue underflow");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("op queue fill level lost a push");

endmodule

`default_nettype wire

/* hw/rtl/bcme_front.sv */
`default_nettype none

module bcme_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bcme_pkg::cfg_t     cfg,
	bcme_in_if.sink                 in_ch,
	input  wire logic               q_full,
	output logic                    q_push,
	output logic [8*bcme_pkg::BLOCK_BYTES-1:0] q_data,
	output bcme_pkg::op_ctrl_t      q_ctrl
);
	import bcme_pkg::*;

	localparam int DW = 8 * BLOCK_BYTES;
	localparam logic [CNT_W:0] BB = (CNT_W + 1)'(BLOCK_BYTES);

	logic          pad_pend_q;  // padding block still to be queued
	logic          accept;
	logic          is_enc;
	logic          full_last;
	logic          short_last;
	logic [CNT_W:0] vb_ext;
	logic [DW-1:0] keep;

	assign vb_ext     = {1'b0, in_ch.valid_bytes};
	assign is_enc     = (cfg.dir == DIR_ENC);
	assign full_last  = is_enc && in_ch.last_block && (vb_ext >= BB);
	assign short_last = is_enc && in_ch.last_block && (vb_ext < BB);

	assign in_ch.ready = !pad_pend_q && !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Byte mask for a short final plaintext block
	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++)
			keep[8*i +: 8] = (vb_ext > (CNT_W + 1)'(i)) ? 8'hFF : 8'h00;
	end

	// Classify the item, or the pending padding block, into a queued op
	always_comb begin
		q_push = accept || (pad_pend_q && !q_full);
		if (pad_pend_q) begin
			q_data = '0;
			q_ctrl = '{first: 1'b0, last: 1'b1, strip: 1'b0};
		end else begin
			q_data = short_last ? (in_ch.in_block & keep) : in_ch.in_block;
			q_ctrl = '{first: in_ch.first_block,
				last: in_ch.last_block && !full_last,
				strip: !is_enc && in_ch.last_block};
		end
	end

	// A full final plaintext block is followed by an all-padding block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_pend_q <= 1'b0;
		end else if (accept && full_last) begin
			pad_pend_q <= 1'b1;
		end else if (pad_pend_q && !q_full) begin
			pad_pend_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bcme_back.sv */
`default_nettype none

module bcme_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bcme_pkg::cfg_t      cfg,
	input  wire logic                q_empty,
	input  wire logic [8*bcme_pkg::BLOCK_BYTES-1:0] q_data,
	input  wire bcme_pkg::op_ctrl_t  q_ctrl,
	output logic                     q_pop,
	bcme_out_if.source               out_ch
);
	import bcme_pkg::*;

	localparam int DW = 8 * BLOCK_BYTES;

	logic [DW-1:0]   chain_q;
	logic            out_valid_q;
	logic [DW-1:0]   out_block_q;
	logic            out_last_q;
	logic [CNT_W-1:0] out_bytes_q;

	logic [DW-1:0]   c_cur;
	logic [DW-1:0]   e_chain;
	logic [DW-1:0]   res;
	logic [DW-1:0]   chain_nxt;
	logic [CNT_W:0]  kept;

	function automatic logic [DW-1:0] enc_blk(input logic [DW-1:0] b,
		input logic [KEY_W-1:0] k);
		logic [DW-1:0] r;
		for (int i = 0; i < BLOCK_BYTES; i++)
			r[8*i +: 8] = b[8*i +: 8] + k;
		return r;
	endfunction

	function automatic logic [DW-1:0] dec_blk(input logic [DW-1:0] b,
		input logic [KEY_W-1:0] k);
		logic [DW-1:0] r;
		for (int i = 0; i < BLOCK_BYTES; i++)
			r[8*i +: 8] = b[8*i +: 8] - k;
		return r;
	endfunction

	// Chain value in effect for this op
	assign c_cur   = q_ctrl.first ? DW'(cfg.iv) : chain_q;
	assign e_chain = enc_blk(c_cur, cfg.key);

	// Mode datapath
	always_comb begin
		res       = '0;
		chain_nxt = c_cur;
		case (cfg.mode)
			MODE_ECB: begin
				res = (cfg.dir == DIR_ENC) ? enc_blk(q_data, cfg.key)
					: dec_blk(q_data, cfg.key);
			end
			MODE_CBC: begin
				if (cfg.dir == DIR_ENC) begin
					res       = enc_blk(q_data ^ c_cur, cfg.key);
					chain_nxt = res;
				end else begin
					res       = dec_blk(q_data, cfg.key) ^ c_cur;
					chain_nxt = q_data;
				end
			end
			MODE_CFB: begin
				res       = q_data ^ e_chain;
				chain_nxt = (cfg.dir == DIR_ENC) ? res : q_data;
			end
			MODE_OFB: begin
				chain_nxt = e_chain;
				res       = q_data ^ e_chain;
			end
			default: begin
				res       = '0;
				chain_nxt = c_cur;
			end
		endcase
	end

	// Bytes left after stripping trailing zeros
	always_comb begin
		kept = '0;
		for (int i = 0; i < BLOCK_BYTES; i++)
			if (res[8*i +: 8] != 8'h00) kept = (CNT_W + 1)'(i + 1);
	end

	assign q_pop = !q_empty && (!out_valid_q || out_ch.ready);

	// Chain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (q_pop) begin
			chain_q <= chain_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_block_q <= res;
			out_last_q  <= q_ctrl.last;
			out_bytes_q <= q_ctrl.strip ? kept[CNT_W-1:0]
				: CNT_W'(BLOCK_BYTES);
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_block = out_block_q;
	assign out_ch.out_last  = out_last_q;
	assign out_ch.out_bytes = out_bytes_q;

endmodule

`default_nettype wire

/* hw/rtl/block_cipher_mode_engine.sv */
`default_nettype none

// Block cipher mode engine: ECB, CBC, CFB and OFB over BLOCK_BYTES-byte blocks.
// in_ch carries plaintext or ciphertext blocks with first/last flags and the
// byte count of a final plaintext block; out_ch carries result blocks with a
// final flag and a byte count. Both are valid/ready; an item moves when both
// are high. Key, mode, direction and IV are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while no item is in flight, as the
// block itself does not enforce it. A result passes through the op queue and
// then the output register before it is valid on out_ch. The engine takes one
// item per cycle while out_ch does not stall; an encrypted full final block
// queues an extra padding block, which drops in_ch.ready until that block is
// queued.
// The front classifies items into ops, a two-entry queue decouples it from
// the back, which owns the chain register and the output register. A stall
// on out_ch fills the queue and then drops in_ch.ready.
// Reset clears all configuration, the chain value and the queue.
module block_cipher_mode_engine (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bcme_in_if.sink                             in_ch,
	bcme_out_if.source                          out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [bcme_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcme_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bcme_pkg::*;

	localparam int DW = 8 * BLOCK_BYTES;

	cfg_t          cfg_q;
	logic          q_full, q_empty, q_push, q_pop;
	logic [DW-1:0] push_data, head_data;
	op_ctrl_t      push_ctrl, head_ctrl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{key: '0, mode: MODE_ECB, dir: DIR_ENC, iv: '0};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KEY:  cfg_q.key  <= cfg_data[KEY_W-1:0];
				REG_MODE: cfg_q.mode <= mode_t'(cfg_data[1:0]);
				REG_DIR:  cfg_q.dir  <= cfg_data[0];
				REG_IV:   cfg_q.iv   <= cfg_data[IV_W-1:0];
				default:  cfg_q      <= cfg_q;
			endcase
		end
	end

	bcme_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (push_data),
		.q_ctrl (push_ctrl)
	);

	bcme_fifo #(.DATA_W(DW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.push_ctrl (push_ctrl),
		.pop       (q_pop),
		.head_data (head_data),
		.head_ctrl (head_ctrl),
		.empty     (q_empty),
		.full      (q_full)
	);

	bcme_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (head_data),
		.q_ctrl  (head_ctrl),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

/* bench/block_cipher_mode_engine_tb.sv */
`timescale 1ns / 1ps

module block_cipher_mode_engine_tb;
	import bcme_pkg::*;

	localparam int NBYTES = BLOCK_BYTES;
	localparam logic [CNT_W-1:0] FULL_BYTES = 3'd4;
	localparam int RAND_ITEMS = 750;

	// One input item and one result block
	typedef struct packed {
		logic [31:0]      blk;
		logic             first;
		logic             last;
		logic [CNT_W-1:0] vb;
	} blk_item_t;

	typedef struct packed {
		logic [31:0]      data;
		logic             last;
		logic [CNT_W-1:0] nbytes;
	} blk_res_t;

	// Directed stimulus row: a register write or an item, optionally with a typed result
	typedef struct packed {
		logic                  is_cfg;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		blk_item_t             item;
		logic                  typed;
		blk_res_t              res;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bcme_in_if #(.DATA_W(32)) in_ch ();
	bcme_out_if #(.DATA_W(32)) out_ch ();

	block_cipher_mode_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the block's configuration and chain register
	logic [KEY_W-1:0] key_r;
	mode_t            mode_r;
	logic             dir_r;
	logic [IV_W-1:0]  iv_r;
	logic [31:0]      chain_r;
	// Chain of the encryption that builds well-formed ciphertext for decrypt runs
	logic [31:0]      ct_chain;

	blk_res_t  cipher_out_q[$];
	plan_row_t dir_plan[$];
	int mismatch_cnt = 0;
	int items_sent = 0;
	int src_idle_pct = 26;
	int snk_idle_pct = 69;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Byte-wise cipher and its inverse
	function automatic logic [31:0] add_key(input logic [31:0] x);
		logic [31:0] r;
		for (int b = 0; b < NBYTES; b++) r[8*b +: 8] = x[8*b +: 8] + key_r;
		return r;
	endfunction

	function automatic logic [31:0] sub_key(input logic [31:0] x);
		logic [31:0] r;
		for (int b = 0; b < NBYTES; b++) r[8*b +: 8] = x[8*b +: 8] - key_r;
		return r;
	endfunction

	// One block through the current mode, updating the given chain
	task automatic crypt_block(input logic dec, input logic [31:0] x,
		inout logic [31:0] chain, output logic [31:0] y);
		case (mode_r)
			MODE_ECB: y = dec ? sub_key(x) : add_key(x);
			MODE_CBC: begin
				if (dec) begin
					y = sub_key(x) ^ chain;
					chain = x;
				end else begin
					chain = add_key(x ^ chain);
					y = chain;
				end
			end
			MODE_CFB: begin
				if (dec) begin
					y = x ^ add_key(chain);
					chain = x;
				end else begin
					chain = x ^ add_key(chain);
					y = chain;
				end
			end
			default: begin
				chain = add_key(chain);
				y = x ^ chain;
			end
		endcase
	endtask

	// Result blocks caused by one accepted item
	task automatic derive_result_blocks(input blk_item_t it, output blk_res_t r0,
		output blk_res_t r1, output int n);
		logic [31:0] y;
		logic [31:0] keep;
		int nb;
		r1 = '0;
		if (it.first) chain_r = iv_r;
		if (dir_r == DIR_DEC) begin
			crypt_block(DIR_DEC, it.blk, chain_r, y);
			nb = NBYTES;
			// strip trailing zero bytes of the final block only
			if (it.last)
				while (nb > 0 && y[8*(nb-1) +: 8] == 8'h00) nb--;
			r0.data = y;
			r0.last = it.last;
			r0.nbytes = nb[CNT_W-1:0];
			n = 1;
		end else if (!it.last || it.vb >= FULL_BYTES) begin
			crypt_block(DIR_ENC, it.blk, chain_r, y);
			r0.data = y;
			r0.last = 1'b0;
			r0.nbytes = FULL_BYTES;
			n = 1;
			// full final block: all-padding block follows
			if (it.last) begin
				crypt_block(DIR_ENC, 32'h0, chain_r, y);
				r1.data = y;
				r1.last = 1'b1;
				r1.nbytes = FULL_BYTES;
				n = 2;
			end
		end else begin
			keep = '0;
			for (int b = 0; b < it.vb; b++) keep[8*b +: 8] = 8'hFF;
			crypt_block(DIR_ENC, it.blk & keep, chain_r, y);
			r0.data = y;
			r0.last = 1'b1;
			r0.nbytes = FULL_BYTES;
			n = 1;
		end
	endtask

	function automatic plan_row_t cfg_row(input reg_idx_t idx, input logic [31:0] data);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic plan_row_t item_row(input logic [31:0] blk, input logic first,
		input logic last, input logic [CNT_W-1:0] vb);
		plan_row_t r;
		r = '0;
		r.item.blk = blk;
		r.item.first = first;
		r.item.last = last;
		r.item.vb = vb;
		return r;
	endfunction

	function automatic plan_row_t item_chk(input logic [31:0] blk, input logic first,
		input logic last, input logic [CNT_W-1:0] vb, input logic [31:0] e_data,
		input logic e_last, input logic [CNT_W-1:0] e_bytes);
		plan_row_t r;
		r = item_row(blk, first, last, vb);
		r.typed = 1'b1;
		r.res.data = e_data;
		r.res.last = e_last;
		r.res.nbytes = e_bytes;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		w = $urandom;
		for (int b = 0; b < NBYTES; b++) begin
			case ($urandom_range(7))
				0: w[8*b +: 8] = 8'h00;
				1: w[8*b +: 8] = 8'hFF;
				default: ;
			endcase
		end
		return w;
	endfunction

	// Register write, only once every expected result is out
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (cipher_out_q.size() != 0) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_KEY:  key_r = data[KEY_W-1:0];
			REG_MODE: mode_r = mode_t'(data[1:0]);
			REG_DIR:  dir_r = data[0];
			default:  iv_r = data[IV_W-1:0];
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Drive one item, predict on acceptance
	task automatic send_item(input blk_item_t it, input logic typed, input blk_res_t tres);
		blk_res_t r0;
		blk_res_t r1;
		int n;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.in_block = it.blk;
		in_ch.first_block = it.first;
		in_ch.last_block = it.last;
		in_ch.valid_bytes = it.vb;
		do @(posedge clk); while (!in_ch.ready);
		derive_result_blocks(it, r0, r1, n);
		if (typed) begin
			cipher_out_q.push_back(tres);
		end else begin
			cipher_out_q.push_back(r0);
			if (n == 2) cipher_out_q.push_back(r1);
		end
		items_sent++;
	endtask

	// Receiver stalls
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin : check_out
		blk_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (cipher_out_q.size() == 0) begin
				$error("out_block: none expected, got %h", out_ch.out_block);
				mismatch_cnt++;
			end else begin
				want = cipher_out_q.pop_front();
				if (out_ch.out_block !== want.data) begin
					$error("out_block: expected %h, got %h", want.data, out_ch.out_block);
					mismatch_cnt++;
				end
				if (out_ch.out_last !== want.last) begin
					$error("out_last: expected %b, got %b", want.last, out_ch.out_last);
					mismatch_cnt++;
				end
				if (out_ch.out_bytes !== want.nbytes) begin
					$error("out_bytes: expected %0d, got %0d", want.nbytes, out_ch.out_bytes);
					mismatch_cnt++;
				end
			end
		end
	end

	// Run limit
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	// Stimulus
	initial begin : stim
		blk_item_t it;
		logic [31:0] p;
		int len;
		int nz;
		int prog;
		int rand_base;
		logic noise;
		logic no_first;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.in_block = '0;
		in_ch.first_block = 1'b0;
		in_ch.last_block = 1'b0;
		in_ch.valid_bytes = '0;
		key_r = '0;
		mode_r = MODE_ECB;
		dir_r = DIR_ENC;
		iv_r = '0;
		chain_r = '0;
		ct_chain = '0;

		// reset config: ECB, encrypt, key 0
		dir_plan.push_back(item_chk(32'h12345678, 1, 0, 4, 32'h12345678, 0, 4));
		dir_plan.push_back(item_chk(32'hAABBCCDD, 0, 1, 2, 32'h0000CCDD, 1, 4));
		// no valid bytes: all padding
		dir_plan.push_back(item_chk(32'hFFFFFFFF, 0, 1, 0, 32'h00000000, 1, 4));
		// valid byte count above block size, then a full final block
		dir_plan.push_back(item_row(32'h80000001, 0, 1, 7));
		dir_plan.push_back(item_row(32'hFFFFFFFF, 0, 1, 4));
		dir_plan.push_back(cfg_row(REG_KEY, 32'hFF));
		dir_plan.push_back(item_chk(32'hFFFFFFFF, 0, 0, 4, 32'hFEFEFEFE, 0, 4));
		dir_plan.push_back(cfg_row(REG_DIR, DIR_DEC));
		dir_plan.push_back(item_chk(32'h00000000, 0, 1, 4, 32'h01010101, 1, 4));
		dir_plan.push_back(item_chk(32'hFF000000, 0, 1, 4, 32'h00010101, 1, 3));
		dir_plan.push_back(cfg_row(REG_KEY, 32'h00));
		// strip down to nothing, and valid_bytes ignored on decrypt
		dir_plan.push_back(item_chk(32'h00000000, 0, 1, 4, 32'h00000000, 1, 0));
		dir_plan.push_back(item_chk(32'h00000012, 0, 1, 0, 32'h00000012, 1, 1));
		// chained modes both ways
		dir_plan.push_back(cfg_row(REG_MODE, MODE_CBC));
		dir_plan.push_back(cfg_row(REG_IV, 32'hFFFFFFFF));
		dir_plan.push_back(cfg_row(REG_DIR, DIR_ENC));
		dir_plan.push_back(cfg_row(REG_KEY, 32'h80));
		dir_plan.push_back(item_row(32'h01234567, 1, 0, 4));
		dir_plan.push_back(item_row(32'h89ABCDEF, 0, 0, 4));
		dir_plan.push_back(item_row(32'h00000000, 0, 1, 4));
		dir_plan.push_back(cfg_row(REG_DIR, DIR_DEC));
		dir_plan.push_back(item_row(32'h5A5A5A5A, 1, 0, 4));
		dir_plan.push_back(item_row(32'hA5A5A5A5, 0, 1, 4));
		dir_plan.push_back(cfg_row(REG_MODE, MODE_CFB));
		dir_plan.push_back(cfg_row(REG_DIR, DIR_ENC));
		dir_plan.push_back(item_row(32'hDEADBEEF, 1, 0, 4));
		dir_plan.push_back(item_row(32'h00C0FFEE, 0, 1, 3));
		dir_plan.push_back(cfg_row(REG_DIR, DIR_DEC));
		dir_plan.push_back(item_row(32'h13579BDF, 1, 1, 4));
		dir_plan.push_back(cfg_row(REG_MODE, MODE_OFB));
		dir_plan.push_back(cfg_row(REG_DIR, DIR_ENC));
		dir_plan.push_back(item_row(32'h11111111, 1, 0, 4));
		dir_plan.push_back(item_row(32'h22222222, 0, 1, 1));
		dir_plan.push_back(cfg_row(REG_DIR, DIR_DEC));
		dir_plan.push_back(item_row(32'h33333333, 1, 0, 4));
		dir_plan.push_back(item_row(32'h44444444, 0, 1, 4));
		// message without a first block: chain carries on
		dir_plan.push_back(item_row(32'h55555555, 0, 1, 4));
		// ECB ignores the chain
		dir_plan.push_back(cfg_row(REG_MODE, MODE_ECB));
		dir_plan.push_back(cfg_row(REG_IV, 32'h0F0F0F0F));
		dir_plan.push_back(item_row(32'h00000000, 1, 1, 4));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_plan[i]) begin
			if (dir_plan[i].is_cfg)
				write_reg(dir_plan[i].idx, dir_plan[i].data);
			else
				send_item(dir_plan[i].item, dir_plan[i].typed, dir_plan[i].res);
		end

		// Random phases: fresh settings, then a few messages
		rand_base = items_sent;
		while (items_sent - rand_base < RAND_ITEMS) begin
			prog = items_sent - rand_base;
			if (prog < RAND_ITEMS / 3) begin
				src_idle_pct = 26;
				snk_idle_pct = 69;
			end else if (prog < 2 * RAND_ITEMS / 3) begin
				src_idle_pct = 69;
				snk_idle_pct = 26;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end

			case ($urandom_range(3))
				0: write_reg(REG_KEY, 32'h00);
				1: write_reg(REG_KEY, 32'hFF);
				default: write_reg(REG_KEY, $urandom_range(255));
			endcase
			write_reg(REG_MODE, $urandom_range(3));
			write_reg(REG_DIR, $urandom_range(1));
			case ($urandom_range(3))
				0: write_reg(REG_IV, 32'h00000000);
				1: write_reg(REG_IV, 32'hFFFFFFFF);
				default: write_reg(REG_IV, $urandom);
			endcase

			repeat ($urandom_range(2, 5)) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
				no_first = ($urandom_range(9) == 0);
				for (int k = 0; k < len; k++) begin
					noise = ($urandom_range(11) == 0);
					it.first = (k == 0) && !no_first;
					it.last = (k == len - 1);
					if (noise) begin
						it.first = $urandom_range(1);
						it.last = $urandom_range(1);
					end
					it.vb = $urandom_range(1) ? FULL_BYTES : CNT_W'($urandom_range(7));
					if (dir_r == DIR_DEC && !noise) begin
						// real ciphertext, so the final block strips padding
						p = rand_word();
						if (it.last) begin
							nz = $urandom_range(NBYTES);
							for (int b = 0; b < nz; b++) p[8*(NBYTES-1-b) +: 8] = 8'h00;
						end
						if (it.first) ct_chain = iv_r;
						crypt_block(DIR_ENC, p, ct_chain, it.blk);
					end else begin
						it.blk = rand_word();
					end
					send_item(it, 1'b0, '0);
				end
			end
		end

		// Drain
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (cipher_out_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/bcme_pkg.sv
hw/rtl/bcme_if.sv
hw/rtl/bcme_fifo.sv
hw/rtl/bcme_front.sv
hw/rtl/bcme_back.sv
hw/rtl/block_cipher_mode_engine.sv
bench/block_cipher_mode_engine_tb.sv
